### design/lrukv_pkg.sv
`default_nettype none
package lrukv_pkg;

  // Fixed field widths
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // Default store depth
  localparam int ENTRIES_DEFAULT = 16;

  // Capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Value returned on a lookup miss
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // Configuration port geometry: one 32-bit register per word
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

  // Operation codes
  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new word
    logic look;    // run the associative compare
    logic commit;  // apply the recency and store update
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_get;
  } dp_stat_t;

endpackage
`default_nettype wire

### design/lrukv_ctrl.sv
`default_nettype none
module lrukv_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire lrukv_pkg::dp_stat_t stat,
  output lrukv_pkg::dp_cmd_t      cmd,
  output logic                    busy,
  output logic                    done
);
  import lrukv_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPDATE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take a word in idle or during the update cycle of the previous one
  assign accept = start && !busy;

  always_comb begin
    case (state)
      S_IDLE:   state_next = accept ? S_LOOK : S_IDLE;
      S_LOOK:   state_next = S_UPDATE;
      S_UPDATE: state_next = accept ? S_LOOK : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Hold state and registered strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next == S_LOOK);
      done  <= (state_next == S_UPDATE) && stat.is_get;
    end
  end

  // Drive datapath commands
  always_comb begin
    cmd.load   = accept;
    cmd.look   = (state == S_LOOK);
    cmd.commit = (state == S_UPDATE);
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not enter lookup");
  a_look_then_commit: assert property (@(posedge clk) disable iff (rst)
    busy |=> (cmd.commit && !busy))
    else $error("lookup not followed by update");
  a_done_in_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> cmd.commit)
    else $error("result strobe outside update cycle");
`endif

endmodule
`default_nettype wire

### design/lrukv_dp.sv
`default_nettype none
module lrukv_dp #(
  parameter int ENTRIES = lrukv_pkg::ENTRIES_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lrukv_pkg::dp_cmd_t           cmd,
  output lrukv_pkg::dp_stat_t               stat,
  input  wire logic [lrukv_pkg::CAP_W-1:0]  capacity,
  input  wire logic                         func,
  input  wire logic [lrukv_pkg::KEY_W-1:0]  key,
  input  wire logic [lrukv_pkg::DATA_W-1:0] put_value,
  output logic                              hit,
  output logic [lrukv_pkg::DATA_W-1:0]      read_value
);
  import lrukv_pkg::*;

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (FW > CAP_W) ? FW : CAP_W;

  // Latched request word
  func_t             func_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] value_q;

  // Store state
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] valid_next;
  logic [KEY_W-1:0]   keys [ENTRIES];
  logic [IW-1:0]      ranks [ENTRIES];
  logic [IW-1:0]      ranks_next [ENTRIES];
  logic [FW-1:0]      fill;
  logic [FW-1:0]      fill_next;
  logic [DATA_W-1:0]  value_mem [ENTRIES];

  // Lookup results, combinational
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] evict_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [IW-1:0]      hit_idx;
  logic [IW-1:0]      hit_rank;
  logic [IW-1:0]      slot_idx;
  logic [FW-1:0]      fill_m1;
  logic [IW-1:0]      oldest_rank;
  logic [CMPW-1:0]    cap_eff;
  logic               need_evict;

  // Lookup results, registered
  logic               hit_q;
  logic [IW-1:0]      hit_idx_q;
  logic [IW-1:0]      hit_rank_q;
  logic [ENTRIES-1:0] evict_vec_q;
  logic               need_evict_q;
  logic [IW-1:0]      slot_idx_q;
  logic               cap_zero_q;
  logic [DATA_W-1:0]  rd_data;

  // Update decode
  logic               do_touch;
  logic               do_insert;
  logic               do_write;
  logic [IW-1:0]      wr_idx;
  logic [ENTRIES-1:0] kept;

  // Capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func_t'(func);
      key_q   <= key;
      value_q <= put_value;
    end
  end

  assign stat.is_get = (func_q == FUNC_GET);

  // Associative compare and per-entry selection
  assign fill_m1     = fill - FW'(1);
  assign oldest_rank = fill_m1[IW-1:0];

  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = valid[i] && (keys[i] == key_q);
      evict_vec[i] = valid[i] && (ranks[i] == oldest_rank);
      if (match[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | ranks[i];
      end
    end
  end

  // Effective capacity saturates at the store depth
  always_comb begin
    if (CMPW'(capacity) > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end else begin
      cap_eff = CMPW'(capacity);
    end
  end

  assign need_evict = (CMPW'(fill) >= cap_eff);
  assign free_vec   = ~valid | (need_evict ? evict_vec : '0);

  // Pick the lowest free slot once the victim is gone
  always_comb begin
    slot_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        slot_idx = IW'(i);
      end
    end
  end

  // Register the lookup and read the stored value
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_q        <= |match;
      hit_idx_q    <= hit_idx;
      hit_rank_q   <= hit_rank;
      evict_vec_q  <= evict_vec;
      need_evict_q <= need_evict;
      slot_idx_q   <= slot_idx;
      cap_zero_q   <= (capacity == '0);
      rd_data      <= value_mem[hit_idx];
    end
  end

  // Decode the update
  assign do_touch  = hit_q && ((func_q == FUNC_GET) || !cap_zero_q);
  assign do_write  = (func_q == FUNC_PUT) && !cap_zero_q;
  assign do_insert = do_write && !hit_q;
  assign wr_idx    = hit_q ? hit_idx_q : slot_idx_q;
  assign kept      = valid & ~(need_evict_q ? evict_vec_q : '0);

  // Age ranks, evict and insert
  always_comb begin
    valid_next = valid;
    ranks_next = ranks;
    fill_next  = fill;
    if (do_touch) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (valid[j] && (ranks[j] < hit_rank_q)) begin
          ranks_next[j] = ranks[j] + IW'(1);
        end
      end
      ranks_next[hit_idx_q] = '0;
    end else if (do_insert) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (kept[j]) begin
          ranks_next[j] = ranks[j] + IW'(1);
        end
      end
      valid_next             = kept;
      valid_next[slot_idx_q] = 1'b1;
      ranks_next[slot_idx_q] = '0;
      if (!need_evict_q) begin
        fill_next = fill + FW'(1);
      end
    end
  end

  // Hold control state of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
    end else if (cmd.commit) begin
      valid <= valid_next;
      fill  <= fill_next;
    end
  end

  // Write payload of the store
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ranks <= ranks_next;
      if (do_insert) begin
        keys[slot_idx_q] <= key_q;
      end
      if (do_write) begin
        value_mem[wr_idx] <= value_q;
      end
    end
  end

  assign hit        = hit_q;
  assign read_value = hit_q ? rd_data : MISS_VALUE;

`ifndef SYNTHESIS
  a_fill_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(fill))
    else $error("fill count disagrees with valid entries");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill) <= ENTRIES)
    else $error("fill count above store depth");
`endif

endmodule
`default_nettype wire

### design/lru_key_value_cache.sv
// Fully associative key/value cache with least-recently-used replacement.
// Pulse start with func (0 get, 1 put), key and put_value while busy is low.
// Each word passes through a lookup state (associative key compare over all
// entries and value memory read), then an update state (recency rank update
// and store write); a new word may be started in the update state of the
// last. A get returns hit and read_value (-1 on a miss) with done high for
// exactly one cycle, in its update state; the receiver cannot stall. A put
// returns nothing. The capacity register (address 0) limits how many entries
// fill before the oldest is evicted; zero makes puts do nothing. The
// store is empty after reset with no clearing pass.
`default_nettype none
module lru_key_value_cache #(
  parameter int ENTRIES = lrukv_pkg::ENTRIES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          func,
  input  wire logic [lrukv_pkg::KEY_W-1:0]   key,
  input  wire logic [lrukv_pkg::DATA_W-1:0]  put_value,
  // Result
  output logic                               done,
  output logic                               hit,
  output logic [lrukv_pkg::DATA_W-1:0]       read_value,
  // Configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lrukv_pkg::PADDR_W-1:0] paddr,
  input  wire logic [lrukv_pkg::PDATA_W-1:0] pwdata,
  output logic [lrukv_pkg::PDATA_W-1:0]      prdata,
  output logic                               pready
);
  import lrukv_pkg::*;

  logic [CAP_W-1:0]     capacity;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  dp_cmd_t              cmd;
  dp_stat_t             stat;

  // Decode the register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CAPACITY) begin
      prdata = PDATA_W'(capacity);
    end
  end

  lrukv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  lrukv_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .capacity   (capacity),
    .func       (func),
    .key        (key),
    .put_value  (put_value),
    .hit        (hit),
    .read_value (read_value)
  );

endmodule
`default_nettype wire

### verif/tb_lru_key_value_cache.sv
`timescale 1ns / 100ps
module tb_lru_key_value_cache;
  import lrukv_pkg::*;

  localparam int CACHE_DEPTH = 16;
  localparam int POOL_SIZE = 20;
  localparam int PHASE_WORDS = 80;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    func_t             op;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
    logic              pinned;
    logic              want_hit;
    logic [DATA_W-1:0] want_value;
  } plan_row_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] value;
  } read_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  func_t word_func = FUNC_GET;
  logic [KEY_W-1:0] word_key = '0;
  logic [DATA_W-1:0] word_value = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic busy;
  logic done;
  logic hit;
  logic [DATA_W-1:0] read_value;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Typed-in expectation riding along with the word
  logic pin_on = 1'b0;
  logic pin_hit = 1'b0;
  logic [DATA_W-1:0] pin_value = '0;

  // Cache shadow
  logic              shadow_valid [CACHE_DEPTH];
  logic [KEY_W-1:0]  shadow_key [CACHE_DEPTH];
  logic [DATA_W-1:0] shadow_value [CACHE_DEPTH];
  int unsigned       shadow_rank [CACHE_DEPTH];
  int unsigned       shadow_fill;
  logic [CAP_W-1:0]  shadow_cap;

  read_t pending_reads [$];
  int error_count = 0;
  int read_count = 0;
  int hit_count = 0;
  int word_count = 0;

  plan_row_t plan [0:25];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  logic [CAP_W-1:0] phase_cap [8];
  int phase_idle [4];

  lru_key_value_cache #(.ENTRIES(CACHE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .func(word_func), .key(word_key), .put_value(word_value),
    .done(done), .hit(hit), .read_value(read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int find_entry(input logic [KEY_W-1:0] k);
    int i;
    for (i = 0; i < CACHE_DEPTH; i++)
      if (shadow_valid[i] && shadow_key[i] == k) return i;
    return -1;
  endfunction

  // Make entry i the most recent and age the ones that were newer
  function automatic void promote(input int i);
    int j;
    int unsigned r;
    r = shadow_rank[i];
    for (j = 0; j < CACHE_DEPTH; j++)
      if (shadow_valid[j] && shadow_rank[j] < r) shadow_rank[j]++;
    shadow_rank[i] = 0;
  endfunction

  function automatic void insert_entry(input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] v);
    int i;
    int oldest;
    int slot;
    int unsigned limit;
    limit = (shadow_cap > CACHE_DEPTH) ? CACHE_DEPTH : shadow_cap;
    oldest = -1;
    slot = -1;
    // Evict the least recent entry when full, even when capacity was lowered
    if (shadow_fill >= limit) begin
      for (i = 0; i < CACHE_DEPTH; i++)
        if (shadow_valid[i] && (oldest < 0 || shadow_rank[i] > shadow_rank[oldest]))
          oldest = i;
      if (oldest >= 0) begin
        shadow_valid[oldest] = 1'b0;
        shadow_fill--;
      end
    end
    for (i = CACHE_DEPTH - 1; i >= 0; i--)
      if (!shadow_valid[i]) slot = i;
    if (slot < 0) return;
    for (i = 0; i < CACHE_DEPTH; i++)
      if (shadow_valid[i]) shadow_rank[i]++;
    shadow_valid[slot] = 1'b1;
    shadow_key[slot] = k;
    shadow_value[slot] = v;
    shadow_rank[slot] = 0;
    shadow_fill++;
  endfunction

  // Apply one word to the shadow; return 1 when it yields a read result
  function automatic bit predict_word(input func_t f, input logic [KEY_W-1:0] k,
                                      input logic [DATA_W-1:0] v, output read_t r);
    int idx;
    idx = find_entry(k);
    r = '{1'b0, MISS_VALUE};
    if (f == FUNC_GET) begin
      if (idx >= 0) begin
        promote(idx);
        r = '{1'b1, shadow_value[idx]};
      end
      return 1'b1;
    end
    if (shadow_cap == 0) return 1'b0;
    if (idx >= 0) begin
      shadow_value[idx] = v;
      promote(idx);
    end else begin
      insert_entry(k, v);
    end
    return 1'b0;
  endfunction

  // Check results, then record the word accepted at this edge
  always @(posedge clk) begin : watch
    read_t want;
    read_t got;
    if (!rst) begin
      if (done) begin
        got = '{hit, read_value};
        if (pending_reads.size() == 0) begin
          flag_error($sformatf("read result with nothing pending: hit %0b value %h",
                               got.hit, got.value));
        end else begin
          want = pending_reads.pop_front();
          read_count++;
          if (got.hit) hit_count++;
          if (got.hit !== want.hit)
            flag_error($sformatf("read %0d: hit %0b, want %0b", read_count, got.hit, want.hit));
          if (got.value !== want.value)
            flag_error($sformatf("read %0d: read_value %h, want %h",
                                 read_count, got.value, want.value));
        end
      end
      if (start && !busy) begin
        word_count++;
        if (predict_word(word_func, word_key, word_value, want)) begin
          if (pin_on) want = '{pin_hit, pin_value};
          pending_reads.push_back(want);
        end
      end
    end
  end

  // Hold a word on the ports until it is taken, after an optional random gap
  task automatic send_word(input func_t f, input logic [KEY_W-1:0] k,
                           input logic [DATA_W-1:0] v, input logic pin,
                           input logic ph, input logic [DATA_W-1:0] pv, input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    word_func <= f;
    word_key <= k;
    word_value <= v;
    pin_on <= pin;
    pin_hit <= ph;
    pin_value <= pv;
    do @(posedge clk); while (busy);
  endtask

  // Stop issuing and wait for every pending read, then let a trailing put finish
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending_reads.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the capacity register, then read it back
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= PDATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_cap = cap;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CAP_W-1:0] !== cap)
      flag_error($sformatf("capacity reads %0d, want %0d", prdata[CAP_W-1:0], cap));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int p;
    int n;
    int idle;
    logic [KEY_W-1:0] k;

    for (n = 0; n < CACHE_DEPTH; n++) begin
      shadow_valid[n] = 1'b0;
      shadow_key[n] = '0;
      shadow_value[n] = '0;
      shadow_rank[n] = 0;
    end
    shadow_fill = 0;
    shadow_cap = CAP_RESET;

    plan = '{
      '{ROW_WORD, FUNC_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b0, MISS_VALUE},
      '{ROW_WORD, FUNC_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_GET, 32'h8000_0000, 32'h0, 1'b1, 1'b1, 32'h7fff_ffff},
      '{ROW_WORD, FUNC_GET, 32'h7fff_ffff, 32'h0, 1'b1, 1'b1, 32'h8000_0000},
      '{ROW_WORD, FUNC_GET, 32'hffff_ffff, 32'h0, 1'b1, 1'b1, 32'hffff_ffff},
      '{ROW_WORD, FUNC_PUT, 32'h0000_0000, 32'h0000_1234, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b1, 32'h0000_1234},
      // shrink below the fill level: entries stay, new keys replace in place
      '{ROW_CAP,  FUNC_GET, 32'h0, 32'd2, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_GET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_PUT, 32'h0000_0055, 32'h0000_0066, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_GET, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_GET, 32'h0000_0055, 32'h0, 1'b0, 1'b0, 32'h0},
      // zero capacity: puts neither insert nor update
      '{ROW_CAP,  FUNC_GET, 32'h0, 32'd0, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_PUT, 32'h0000_0055, 32'h0000_0077, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_PUT, 32'h0000_0099, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_GET, 32'h0000_0055, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_GET, 32'h0000_0099, 32'h0, 1'b1, 1'b0, MISS_VALUE},
      // capacity above the depth saturates
      '{ROW_CAP,  FUNC_GET, 32'h0, 32'd31, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_PUT, 32'h0000_0099, 32'haaaa_5555, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_GET, 32'h0000_0099, 32'h0, 1'b0, 1'b0, 32'h0},
      '{ROW_CAP,  FUNC_GET, 32'h0, 32'd1, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_PUT, 32'h0000_0123, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
      '{ROW_WORD, FUNC_GET, 32'h0000_0099, 32'h0, 1'b0, 1'b0, 32'h0}
    };
    phase_cap = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd6, 5'd16, 5'd2};
    phase_idle = '{0, 56, 0, 14};
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hffff_ffff;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (n = 4; n < POOL_SIZE; n++) key_pool[n] = $urandom;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CAP) begin
        drain();
        write_capacity(plan[r].value[CAP_W-1:0]);
      end else begin
        send_word(plan[r].op, plan[r].key, plan[r].value, plan[r].pinned,
                  plan[r].want_hit, plan[r].want_value, 0);
      end
    end

    // Random phases over a small key pool so hits and evictions are frequent
    for (p = 0; p < $size(phase_cap); p++) begin
      drain();
      write_capacity(phase_cap[p]);
      idle = phase_idle[p % $size(phase_idle)];
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (p == 1 && n == PHASE_WORDS / 2) drain();
        k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : $urandom;
        send_word(func_t'($urandom_range(0, 1)), k, $urandom, 1'b0, 1'b0, '0, idle);
      end
    end

    drain();
    $display("Covered %0d words over %0d capacity settings; %0d reads checked, %0d hits.",
             word_count, $size(phase_cap) + 5, read_count, hit_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
